### hdl/bba_pkg.sv
// Shared types, constants and tree index helpers for the buddy block allocator.
package bba_pkg;

    localparam int LEVELS = 10;
    localparam int OFF_W  = LEVELS;
    localparam int IDX_W  = LEVELS + 1;
    localparam int LVL_W  = 4;
    localparam int REQ_W  = 11;
    localparam int NODES  = 2 << LEVELS;
    localparam int POOL   = 1 << LEVELS;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;
    localparam logic [1:0] ST_BADOFF  = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [REQ_W-1:0]  request_units;
        logic [OFF_W-1:0]  block_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  granted_offset;
        logic [LVL_W-1:0]  granted_level;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       clr_step;
        logic       load;
        logic       rd_scan;
        logic       rd_merge;
        logic       rd_ord;
        logic       scan_next;
        logic       take;
        logic       split_step;
        logic       alloc_fin;
        logic       free_start;
        logic       merge_step;
        logic       free_fin;
        logic       emit;
        logic [1:0] emit_status;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic map_hit;
        logic ord_zero;
        logic last_in_level;
        logic lvl_max;
        logic lvl_gt_want;
        logic clr_last;
        logic is_free;
        logic too_large;
    } ctl_sts_t;

    // Heap index of the first node of a level
    function automatic logic [IDX_W-1:0] first_node(input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] one;
        one = {{(IDX_W-1){1'b0}}, 1'b1};
        return one << (LVL_W'(LEVELS) - lvl);
    endfunction

    // Heap index of the node of a level at a unit offset
    function automatic logic [IDX_W-1:0] node_index(input logic [LVL_W-1:0] lvl,
                                                    input logic [OFF_W-1:0] off);
        logic [IDX_W-1:0] sh;
        sh = {1'b0, off} >> lvl;
        return first_node(lvl) + sh;
    endfunction

endpackage

### hdl/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller plus datapath.
//
// Channel   Direction  Signals                  Transfer
// request   in         start, busy, request     start high and busy low at clk edge
// result    out        done, result             done high for one cycle, always taken
//
// Allocate: one map read per tree node scanned, from the request level upward,
// then one split step per level down to the request level.
// Free: an order read and check, then one buddy map read per merge up the tree, then a close.
// After reset a clearing pass over the free map and order store holds busy high.
// The result receiver cannot stall; a new item may start in the cycle the result shows.
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bba_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

endmodule

### hdl/bba_ctrl.sv
// Sequencer for clearing, allocate search and split, and free with buddy merge.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd,
    output logic     busy
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ARD   = 4'd2;
    localparam logic [3:0] S_ACHK  = 4'd3;
    localparam logic [3:0] S_SPLIT = 4'd4;
    localparam logic [3:0] S_FRD   = 4'd5;
    localparam logic [3:0] S_FCHK  = 4'd6;
    localparam logic [3:0] S_MRD   = 4'd7;
    localparam logic [3:0] S_MCHK  = 4'd8;
    localparam logic [3:0] S_FEND  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (sts.is_free)
                    begin
                        state_next = S_FRD;
                    end
                    else if (sts.too_large)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_TOOBIG;
                    end
                    else
                    begin
                        state_next = S_ARD;
                    end
                end
            end
            S_ARD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_ACHK;
            end
            S_ACHK:
            begin
                if (sts.map_hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_SPLIT;
                end
                else if (sts.last_in_level && sts.lvl_max)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOSPACE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_ARD;
                end
            end
            S_SPLIT:
            begin
                if (sts.lvl_gt_want)
                begin
                    cmd.split_step = 1'b1;
                end
                else
                begin
                    cmd.alloc_fin   = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_FRD:
            begin
                cmd.rd_ord = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (sts.ord_zero)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_BADOFF;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.free_start = 1'b1;
                    state_next     = S_MRD;
                end
            end
            S_MRD:
            begin
                if (sts.lvl_max)
                begin
                    state_next = S_FEND;
                end
                else
                begin
                    cmd.rd_merge = 1'b1;
                    state_next   = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (sts.map_hit)
                begin
                    cmd.merge_step = 1'b1;
                    state_next     = S_MRD;
                end
                else
                begin
                    state_next = S_FEND;
                end
            end
            S_FEND:
            begin
                cmd.free_fin    = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_OK;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/bba_dp.sv
// Datapath: free node map, order store, walk registers and result register.
module bba_dp
    import bba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     request,
    input  ctl_cmd_t cmd,
    output ctl_sts_t sts,
    output rsp_t     result,
    output logic     done
);

    // Memories
    logic             free_map_mem [NODES];
    logic [LVL_W-1:0] order_mem    [POOL];

    logic             map_q;
    logic [LVL_W-1:0] ord_q;

    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [LVL_W-1:0] want_reg, want_next;
    logic             done_reg;
    rsp_t             result_reg;

    logic [LVL_W-1:0] want_in;
    logic [IDX_W-1:0] first;
    logic [OFF_W-1:0] lvl_bit;
    logic [OFF_W-1:0] half_bit;
    logic [LVL_W-1:0] lvl_dec;
    logic [IDX_W-1:0] buddy_idx;
    logic [IDX_W-1:0] map_ra;
    logic             map_re;
    logic             map_we;
    logic [IDX_W-1:0] map_wa;
    logic             map_wd;
    logic             ord_we;
    logic [OFF_W-1:0] ord_wa;
    logic [LVL_W-1:0] ord_wd;

    // Rounded level of the request
    always_comb
    begin
        want_in = '0;
        for (int w = LEVELS; w >= 0; w--)
        begin
            if ((12'd1 << w) >= {1'b0, request.request_units})
            begin
                want_in = LVL_W'(w);
            end
        end
    end

    assign first     = first_node(lvl_reg);
    assign lvl_bit   = OFF_W'({{(IDX_W-1){1'b0}}, 1'b1} << lvl_reg);
    assign lvl_dec   = lvl_reg - LVL_W'(1);
    // Offset of the upper half after one split
    assign half_bit  = OFF_W'({{(IDX_W-1){1'b0}}, 1'b1} << lvl_dec);
    assign buddy_idx = node_index(lvl_reg, off_reg ^ lvl_bit);

    // Status to controller
    assign sts.map_hit       = map_q;
    assign sts.ord_zero      = (ord_q == '0);
    assign sts.last_in_level = (idx_reg == ((first << 1) - IDX_W'(1)));
    assign sts.lvl_max       = (lvl_reg == LVL_W'(LEVELS));
    assign sts.lvl_gt_want   = (lvl_reg > want_reg);
    assign sts.clr_last      = &clr_reg;
    assign sts.is_free       = (request.opcode == OP_FREE);
    assign sts.too_large     = ({1'b0, request.request_units} > 12'(POOL));

    // Map port selection
    always_comb
    begin
        map_re = cmd.rd_scan | cmd.rd_merge;
        map_ra = cmd.rd_merge ? buddy_idx : idx_reg;
        map_we = 1'b0;
        map_wa = '0;
        map_wd = 1'b0;
        priority if (cmd.clr_step)
        begin
            map_we = 1'b1;
            map_wa = clr_reg;
            map_wd = (clr_reg == IDX_W'(1));
        end
        else if (cmd.take)
        begin
            map_we = 1'b1;
            map_wa = idx_reg;
        end
        else if (cmd.split_step)
        begin
            map_we = 1'b1;
            map_wa = node_index(lvl_dec, off_reg | half_bit);
            map_wd = 1'b1;
        end
        else if (cmd.merge_step)
        begin
            map_we = 1'b1;
            map_wa = buddy_idx;
        end
        else if (cmd.free_fin)
        begin
            map_we = 1'b1;
            map_wa = node_index(lvl_reg, off_reg);
            map_wd = 1'b1;
        end
    end

    // Order port selection
    always_comb
    begin
        ord_we = 1'b0;
        ord_wa = off_reg;
        ord_wd = '0;
        priority if (cmd.clr_step)
        begin
            ord_we = 1'b1;
            ord_wa = clr_reg[OFF_W-1:0];
        end
        else if (cmd.alloc_fin)
        begin
            ord_we = 1'b1;
            ord_wd = want_reg + LVL_W'(1);
        end
        else if (cmd.free_start)
        begin
            ord_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            free_map_mem[map_wa] <= map_wd;
        end
        if (map_re)
        begin
            map_q <= free_map_mem[map_ra];
        end
        if (ord_we)
        begin
            order_mem[ord_wa] <= ord_wd;
        end
        if (cmd.rd_ord)
        begin
            ord_q <= order_mem[off_reg];
        end
    end

    // Walk register updates
    always_comb
    begin
        idx_next  = idx_reg;
        off_next  = off_reg;
        lvl_next  = lvl_reg;
        want_next = want_reg;
        priority if (cmd.load)
        begin
            off_next  = request.block_offset;
            want_next = want_in;
            lvl_next  = want_in;
            idx_next  = first_node(want_in);
        end
        else if (cmd.scan_next)
        begin
            if (sts.last_in_level)
            begin
                lvl_next = lvl_reg + LVL_W'(1);
                idx_next = first >> 1;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        else if (cmd.take)
        begin
            off_next = OFF_W'((idx_reg & (first - IDX_W'(1))) << lvl_reg);
        end
        else if (cmd.split_step)
        begin
            lvl_next = lvl_dec;
        end
        else if (cmd.free_start)
        begin
            lvl_next = ord_q - LVL_W'(1);
        end
        else if (cmd.merge_step)
        begin
            off_next = off_reg & ~lvl_bit;
            lvl_next = lvl_reg + LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            lvl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            lvl_reg  <= lvl_next;
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        off_reg  <= off_next;
        want_reg <= want_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.status <= cmd.emit_status;
            unique case (cmd.emit_status)
                ST_OK:
                begin
                    result_reg.granted_offset <= off_reg;
                    result_reg.granted_level  <= lvl_reg;
                end
                ST_NOSPACE:
                begin
                    result_reg.granted_offset <= '0;
                    result_reg.granted_level  <= want_reg;
                end
                ST_TOOBIG:
                begin
                    result_reg.granted_offset <= '0;
                    result_reg.granted_level  <= '0;
                end
                ST_BADOFF:
                begin
                    result_reg.granted_offset <= off_reg;
                    result_reg.granted_level  <= '0;
                end
                default:
                begin
                    result_reg.granted_offset <= '0;
                    result_reg.granted_level  <= '0;
                end
            endcase
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef NO_ASSERTIONS
    // Walk level never leaves the tree
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_W'(LEVELS))
        else $error("walk level out of range");

    // Reported level fits the pool
    a_res_level: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> result_reg.granted_level <= LVL_W'(LEVELS))
        else $error("reported level out of range");

    // Granted blocks are aligned to their size
    a_res_align: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status == ST_OK) |->
        ((result_reg.granted_offset &
          (OFF_W'({{(IDX_W-1){1'b0}}, 1'b1} << result_reg.granted_level) - OFF_W'(1)))
         == '0))
        else $error("granted block not aligned");
`endif

endmodule
